// File: src/hbrp_pkg.sv
package hbrp_pkg;

  localparam int unsigned TOK_DEPTH = 2;
  localparam int unsigned PFX_LEN = 6;
  localparam int unsigned PFX_IDX_W = 3;

  localparam logic [7:0] UNIT_TEXT [PFX_LEN] = '{8'h62, 8'h79, 8'h74, 8'h65, 8'h73, 8'h3d};

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_LEAD,
    PH_FIRST,
    PH_LAST,
    PH_TRAIL
  } phase_e;

  typedef enum logic [2:0] {
    TOK_DIGIT,
    TOK_DASH,
    TOK_SPACE,
    TOK_OTHER,
    TOK_END
  } tok_kind_e;

  typedef enum logic [1:0] {
    ST_IGNORE = 2'd0,
    ST_OK     = 2'd1,
    ST_UNSAT  = 2'd2
  } status_e;

  typedef struct packed {
    tok_kind_e           kind;
    logic [3:0]          digit;
    logic [PFX_LEN-1:0]  pfx_hit;
    logic [31:0]         size;
  } tok_t;

endpackage

// File: src/hbrp_front.sv
module hbrp_front
  import hbrp_pkg::*;
(
  input  logic [7:0]  header_char_i,
  input  logic        terminator_i,
  input  logic [31:0] resource_size_i,
  output tok_t        tok_o
);

  logic [7:0] lower;
  logic       is_digit;

  always_comb begin
    lower = header_char_i;
    if (header_char_i >= CH_UPPER_A && header_char_i <= CH_UPPER_Z) begin
      lower = header_char_i + CASE_OFFSET;
    end
    is_digit = (header_char_i >= CH_ZERO) && (header_char_i <= CH_NINE);
  end

  always_comb begin
    tok_o.digit = header_char_i[3:0];
    tok_o.size = resource_size_i;
    for (int k = 0; k < PFX_LEN; k++) begin
      tok_o.pfx_hit[k] = (lower == UNIT_TEXT[k]);
    end
    priority if (terminator_i) begin
      tok_o.kind = TOK_END;
    end else if (is_digit) begin
      tok_o.kind = TOK_DIGIT;
    end else if (header_char_i == CH_DASH) begin
      tok_o.kind = TOK_DASH;
    end else if (header_char_i == CH_SPACE) begin
      tok_o.kind = TOK_SPACE;
    end else begin
      tok_o.kind = TOK_OTHER;
    end
  end

endmodule

// File: src/hbrp_fifo.sv
module hbrp_fifo
  import hbrp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  tok_t wr_tok_i,
  output logic full_o,
  input  logic rd_i,
  output logic empty_o,
  output tok_t rd_tok_o
);

  localparam int unsigned PTR_W = (TOK_DEPTH > 1) ? $clog2(TOK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TOK_DEPTH + 1);

  tok_t             mem_q [TOK_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o = (cnt_q == CNT_W'(TOK_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rd_tok_o = mem_q[rd_ptr_q];
  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(TOK_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(TOK_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_tok_i;
    end
  end

endmodule

// File: src/hbrp_back.sv
module hbrp_back
  import hbrp_pkg::*;
#(
  parameter int unsigned POS_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tok_valid_i,
  input  tok_t        tok_i,
  output logic        tok_take_o,
  input  logic        pop_i,
  output logic        out_valid_o,
  output logic [1:0]  range_status_o,
  output logic [31:0] range_first_o,
  output logic [31:0] range_last_o
);

  typedef logic [POS_BITS-1:0] pos_t;

  phase_e               phase_q, phase_d;
  logic [PFX_IDX_W-1:0] pfx_idx_q, pfx_idx_d;
  pos_t                 first_acc_q, first_acc_d;
  pos_t                 last_acc_q, last_acc_d;
  logic                 saw_first_q, saw_first_d;
  logic                 saw_last_q, saw_last_d;
  logic                 malformed_q, malformed_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  pos_t                 res_first_q, res_first_d;
  pos_t                 res_last_q, res_last_d;

  logic    is_end;
  logic    take_char;
  logic    pfx_ok;
  pos_t    size;
  pos_t    size_m1;
  status_e calc_status;
  pos_t    calc_first;
  pos_t    calc_last;

  function automatic pos_t acc_digit(input pos_t acc, input logic [3:0] d);
    logic [POS_BITS+3:0] ext;
    logic [POS_BITS+3:0] wide;
    ext = {4'b0, acc};
    wide = (ext << 3) + (ext << 1) + {{POS_BITS{1'b0}}, d};
    if (wide[POS_BITS+3:POS_BITS] != 4'b0) begin
      return '1;
    end
    return wide[POS_BITS-1:0];
  endfunction

  assign is_end = (tok_i.kind == TOK_END);
  assign tok_take_o = tok_valid_i && (!is_end || !out_valid_q || pop_i);
  assign take_char = tok_take_o && !is_end && !malformed_q;
  assign pfx_ok = (pfx_idx_q < PFX_IDX_W'(PFX_LEN)) && tok_i.pfx_hit[pfx_idx_q];
  assign size = POS_BITS'(tok_i.size);
  assign size_m1 = size - 1'b1;

  always_comb begin
    phase_d = phase_q;
    if (tok_take_o && is_end) begin
      phase_d = PH_PREFIX;
    end else if (take_char) begin
      unique case (phase_q)
        PH_PREFIX: begin
          if (pfx_ok && pfx_idx_q == PFX_IDX_W'(PFX_LEN - 1)) begin
            phase_d = PH_LEAD;
          end
        end
        PH_LEAD: begin
          if (tok_i.kind == TOK_DIGIT) begin
            phase_d = PH_FIRST;
          end else if (tok_i.kind == TOK_DASH) begin
            phase_d = PH_LAST;
          end
        end
        PH_FIRST: begin
          if (tok_i.kind == TOK_DASH) begin
            phase_d = PH_LAST;
          end
        end
        PH_LAST: begin
          if (tok_i.kind == TOK_SPACE) begin
            phase_d = PH_TRAIL;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    pfx_idx_d = pfx_idx_q;
    first_acc_d = first_acc_q;
    last_acc_d = last_acc_q;
    saw_first_d = saw_first_q;
    saw_last_d = saw_last_q;
    malformed_d = malformed_q;
    if (tok_take_o && is_end) begin
      pfx_idx_d = '0;
      first_acc_d = '0;
      last_acc_d = '0;
      saw_first_d = 1'b0;
      saw_last_d = 1'b0;
      malformed_d = 1'b0;
    end else if (take_char) begin
      unique case (phase_q)
        PH_PREFIX: begin
          if (pfx_ok) begin
            pfx_idx_d = pfx_idx_q + 1'b1;
          end else begin
            malformed_d = 1'b1;
          end
        end
        PH_LEAD: begin
          if (tok_i.kind == TOK_DIGIT) begin
            saw_first_d = 1'b1;
            first_acc_d = acc_digit(first_acc_q, tok_i.digit);
          end else if (tok_i.kind != TOK_SPACE && tok_i.kind != TOK_DASH) begin
            malformed_d = 1'b1;
          end
        end
        PH_FIRST: begin
          if (tok_i.kind == TOK_DIGIT) begin
            first_acc_d = acc_digit(first_acc_q, tok_i.digit);
          end else if (tok_i.kind != TOK_DASH) begin
            malformed_d = 1'b1;
          end
        end
        PH_LAST: begin
          if (tok_i.kind == TOK_DIGIT) begin
            saw_last_d = 1'b1;
            last_acc_d = acc_digit(last_acc_q, tok_i.digit);
          end else if (tok_i.kind != TOK_SPACE) begin
            malformed_d = 1'b1;
          end
        end
        default: begin
          if (tok_i.kind != TOK_SPACE) begin
            malformed_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    calc_status = ST_IGNORE;
    calc_first = '0;
    calc_last = '0;
    if (!malformed_q && (phase_q == PH_LAST || phase_q == PH_TRAIL)) begin
      if (!saw_first_q) begin
        if (!saw_last_q || last_acc_q == '0 || size == '0) begin
          calc_status = ST_UNSAT;
        end else begin
          calc_status = ST_OK;
          calc_first = (last_acc_q >= size) ? '0 : size - last_acc_q;
          calc_last = size_m1;
        end
      end else if (first_acc_q >= size) begin
        calc_status = ST_UNSAT;
      end else begin
        calc_first = first_acc_q;
        calc_last = (!saw_last_q || last_acc_q >= size) ? size_m1 : last_acc_q;
        calc_status = (calc_first > calc_last) ? ST_UNSAT : ST_OK;
      end
    end
    if (calc_status != ST_OK) begin
      calc_first = '0;
      calc_last = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d = status_q;
    res_first_d = res_first_q;
    res_last_d = res_last_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (tok_take_o && is_end) begin
      out_valid_d = 1'b1;
      status_d = calc_status;
      res_first_d = calc_first;
      res_last_d = calc_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      pfx_idx_q <= '0;
      first_acc_q <= '0;
      last_acc_q <= '0;
      saw_first_q <= 1'b0;
      saw_last_q <= 1'b0;
      malformed_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pfx_idx_q <= pfx_idx_d;
      first_acc_q <= first_acc_d;
      last_acc_q <= last_acc_d;
      saw_first_q <= saw_first_d;
      saw_last_q <= saw_last_d;
      malformed_q <= malformed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    res_first_q <= res_first_d;
    res_last_q <= res_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign range_status_o = status_q;
  assign range_first_o = 32'(res_first_q);
  assign range_last_o = 32'(res_last_q);

endmodule

// File: src/http_byte_range_parser_top.sv
// Throughput: one beat per cycle on the input side while full is low, with no bubbles between headers.
// A terminator beat is first written into the token queue; the parser then loads its result into the
// result register and empty goes low, unless a stalled result side keeps the token in the queue.
// A two-entry token queue separates the classifier from the parser, and a one-entry result
// register separates the parser from the result side.
// Reset is asynchronous and active low; it empties both queues and restarts prefix matching.
module http_byte_range_parser_top
  import hbrp_pkg::*;
#(
  parameter int unsigned POS_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  header_char_i,
  input  logic        terminator_i,
  input  logic [31:0] resource_size_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  range_status_o,
  output logic [31:0] range_first_o,
  output logic [31:0] range_last_o
);

  tok_t front_tok;
  tok_t head_tok;
  logic fifo_empty;
  logic tok_take;
  logic out_valid;

  hbrp_front u_front (
    .header_char_i   (header_char_i),
    .terminator_i    (terminator_i),
    .resource_size_i (resource_size_i),
    .tok_o           (front_tok)
  );

  hbrp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_tok_i (front_tok),
    .full_o   (full),
    .rd_i     (tok_take),
    .empty_o  (fifo_empty),
    .rd_tok_o (head_tok)
  );

  hbrp_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_valid_i    (!fifo_empty),
    .tok_i          (head_tok),
    .tok_take_o     (tok_take),
    .pop_i          (pop && out_valid),
    .out_valid_o    (out_valid),
    .range_status_o (range_status_o),
    .range_first_o  (range_first_o),
    .range_last_o   (range_last_o)
  );

  assign empty = !out_valid;

endmodule
